// ----- rtl/sfl_pkg.sv -----
// shared constants, types and status codes of the size class free list allocator
package sfl_pkg;

    localparam int NUM_CLASSES      = 16;
    localparam int ALIGN_BYTES      = 8;
    localparam int BLOCKS_PER_CHUNK = 16;
    localparam int NUM_CHUNKS       = 64;
    localparam int LARGEST_POOLED   = 128;

    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 10;
    localparam int CLASS_W  = 4;

    localparam int POOL_BLOCKS = NUM_CHUNKS * BLOCKS_PER_CHUNK;
    localparam int IDX_W       = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int LINK_W      = $clog2(POOL_BLOCKS + 1);
    localparam int NULL_HANDLE = POOL_BLOCKS;
    localparam int CHUNK_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CNT_W       = $clog2(NUM_CHUNKS + 1);
    localparam int SLOT_W      = (BLOCKS_PER_CHUNK > 1) ? $clog2(BLOCKS_PER_CHUNK) : 1;
    localparam int HEAD_IW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SZ_W        = $clog2(LARGEST_POOLED + 1);
    localparam int QW          = $clog2(LARGEST_POOLED + ALIGN_BYTES + NUM_CLASSES) + 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERSIZE  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic               bad;
        logic               over;
        logic [CLASS_W-1:0] cls;
    } t_size_dec;

endpackage

// ----- rtl/sfl_ram.sv -----
// generic single port synchronous ram with registered read data
module sfl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sfl_size_decode.sv -----
// maps a requested byte count to a size class or a rejection
module sfl_size_decode (
    input  logic [sfl_pkg::SIZE_W-1:0] i_size_bytes,
    output sfl_pkg::t_size_dec         o_dec
);
    import sfl_pkg::*;

    logic [SZ_W-1:0] sz;
    logic [QW-1:0]   sum;
    logic [QW-1:0]   quot;

    always_comb begin
        sz   = i_size_bytes[SZ_W-1:0];
        sum  = QW'(sz) + QW'(ALIGN_BYTES - 1);
        // ceiling divide by the alignment, one less gives the class
        quot = QW'(sum / ALIGN_BYTES);
        o_dec.bad  = (i_size_bytes == '0);
        o_dec.over = (i_size_bytes > SIZE_W'(LARGEST_POOLED)) || (quot > QW'(NUM_CLASSES));
        o_dec.cls  = CLASS_W'(quot - QW'(1));
    end
endmodule

// ----- rtl/size_class_free_list_allocator_core.sv -----
// top level of the size class free list allocator
// One command per transfer on start while busy is low; one result per command
// on o_strobe for a single cycle, which the receiver must take. Zero sizes,
// oversize requests and bad frees answer the cycle after the transfer with
// busy never raised. A free makes one read of the chunk tag memory, then pushes
// the block onto its class list. An allocate from a non-empty list looks at the
// class head, then makes one read of the link memory for the successor. An
// allocate that finds its list empty carves the next chunk while one is left,
// writing one link per cycle, or else answers exhausted. Tags are kept per
// chunk and qualified by the carved chunk count, so no clearing pass follows reset.
module size_class_free_list_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [sfl_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [sfl_pkg::HANDLE_W-1:0] i_block_handle,
    output logic                         o_strobe,
    output sfl_pkg::t_status             o_status,
    output logic [sfl_pkg::HANDLE_W-1:0] o_handle,
    output logic [sfl_pkg::CLASS_W-1:0]  o_size_class
);
    import sfl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_POP   = 5'b00100,
        S_CARVE = 5'b01000,
        S_TAG   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CLASS_W-1:0]  r_cls, n_cls;
    logic [LINK_W-1:0]   r_h, n_h;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_chunks, n_chunks;
    logic [LINK_W-1:0]   r_base, n_base;
    logic [LINK_W-1:0]   r_heads [NUM_CLASSES];
    logic                r_strobe, n_strobe;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [CLASS_W-1:0]  r_class, n_class;

    t_size_dec           dec;
    logic                accept;
    logic [CHUNK_W-1:0]  in_chunk;
    logic                free_ok;
    logic [LINK_W-1:0]   head;
    logic [LINK_W-1:0]   carve_addr;
    logic                carve_last;

    logic                heads_we;
    logic [HEAD_IW-1:0]  heads_waddr;
    logic [LINK_W-1:0]   heads_wdata;

    logic                link_we;
    logic [IDX_W-1:0]    link_addr;
    logic [LINK_W-1:0]   link_wdata;
    logic [LINK_W-1:0]   link_rdata;

    logic                tag_we;
    logic [CHUNK_W-1:0]  tag_addr;
    logic [CLASS_W-1:0]  tag_rdata;

    sfl_size_decode u_dec (
        .i_size_bytes (i_size_bytes),
        .o_dec        (dec)
    );

    sfl_ram #(.DEPTH(POOL_BLOCKS), .WIDTH(LINK_W)) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_addr  (link_addr),
        .i_wdata (link_wdata),
        .o_rdata (link_rdata)
    );

    sfl_ram #(.DEPTH(NUM_CHUNKS), .WIDTH(CLASS_W)) u_tags (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_addr  (tag_addr),
        .i_wdata (r_cls),
        .o_rdata (tag_rdata)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign in_chunk   = CHUNK_W'(i_block_handle / BLOCKS_PER_CHUNK);
    // a block is carved once its chunk lies below the carved count
    assign free_ok    = (LINK_W'(i_block_handle) < LINK_W'(POOL_BLOCKS))
                        && (CNT_W'(in_chunk) < r_chunks);
    assign head       = r_heads[r_cls[HEAD_IW-1:0]];
    assign carve_addr = r_base + LINK_W'(r_slot);
    assign carve_last = (r_slot == SLOT_W'(BLOCKS_PER_CHUNK - 1));

    always_comb begin
        n_state  = r_state;
        n_cls    = r_cls;
        n_h      = r_h;
        n_slot   = r_slot;
        n_chunks = r_chunks;
        n_base   = r_base;
        n_strobe = 1'b0;
        n_status = r_status;
        n_handle = r_handle;
        n_class  = r_class;

        heads_we    = 1'b0;
        heads_waddr = r_cls[HEAD_IW-1:0];
        heads_wdata = link_rdata;
        link_we     = 1'b0;
        link_addr   = head[IDX_W-1:0];
        link_wdata  = carve_addr + LINK_W'(1);
        tag_we      = 1'b0;
        tag_addr    = in_chunk;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_handle = '0;
                    n_class  = '0;
                    if (i_cmd == CMD_ALLOC) begin
                        if (dec.bad) begin
                            n_strobe = 1'b1;
                            n_status = ST_BAD;
                        end else if (dec.over) begin
                            n_strobe = 1'b1;
                            n_status = ST_OVERSIZE;
                        end else begin
                            n_cls   = dec.cls;
                            n_state = S_LOOK;
                        end
                    end else begin
                        if (!free_ok) begin
                            n_strobe = 1'b1;
                            n_status = ST_BAD;
                        end else begin
                            // chunk tag read is issued in this cycle
                            n_h     = LINK_W'(i_block_handle);
                            n_state = S_TAG;
                        end
                    end
                end
            end
            S_LOOK: begin
                if (head == LINK_W'(NULL_HANDLE)) begin
                    if (r_chunks == CNT_W'(NUM_CHUNKS)) begin
                        n_strobe = 1'b1;
                        n_status = ST_EXHAUSTED;
                        n_state  = S_IDLE;
                    end else begin
                        n_slot  = '0;
                        n_state = S_CARVE;
                    end
                end else begin
                    n_h     = head;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                heads_we    = 1'b1;
                heads_wdata = link_rdata;
                n_strobe    = 1'b1;
                n_status    = ST_OK;
                n_handle    = HANDLE_W'(r_h);
                n_class     = r_cls;
                n_state     = S_IDLE;
            end
            S_CARVE: begin
                link_we   = 1'b1;
                link_addr = carve_addr[IDX_W-1:0];
                tag_addr  = r_chunks[CHUNK_W-1:0];
                tag_we    = (r_slot == '0);
                if (carve_last) begin
                    link_wdata = LINK_W'(NULL_HANDLE);
                    // the first block goes out now, its successor becomes the head
                    heads_we    = 1'b1;
                    heads_wdata = (BLOCKS_PER_CHUNK > 1) ? r_base + LINK_W'(1)
                                                         : LINK_W'(NULL_HANDLE);
                    n_chunks    = r_chunks + CNT_W'(1);
                    n_base      = r_base + LINK_W'(BLOCKS_PER_CHUNK);
                    n_strobe    = 1'b1;
                    n_status    = ST_OK;
                    n_handle    = HANDLE_W'(r_base);
                    n_class     = r_cls;
                    n_state     = S_IDLE;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_TAG: begin
                link_we     = 1'b1;
                link_addr   = r_h[IDX_W-1:0];
                link_wdata  = r_heads[tag_rdata[HEAD_IW-1:0]];
                heads_we    = 1'b1;
                heads_waddr = tag_rdata[HEAD_IW-1:0];
                heads_wdata = r_h;
                n_strobe    = 1'b1;
                n_status    = ST_OK;
                n_handle    = HANDLE_W'(r_h);
                n_class     = tag_rdata;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_chunks <= '0;
            r_base   <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_heads[i] <= LINK_W'(NULL_HANDLE);
            end
        end else begin
            r_state  <= n_state;
            r_chunks <= n_chunks;
            r_base   <= n_base;
            r_strobe <= n_strobe;
            if (heads_we) begin
                r_heads[heads_waddr] <= heads_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_h      <= n_h;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_handle <= n_handle;
        r_class  <= n_class;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_handle     = r_handle;
    assign o_size_class = r_class;
endmodule

// ----- rtl/sfl_checker.sv -----
// port level checks of the allocator core and their binding
module sfl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_cmd,
    input logic [sfl_pkg::SIZE_W-1:0]   i_size_bytes,
    input logic                         o_strobe,
    input sfl_pkg::t_status             o_status,
    input logic [sfl_pkg::HANDLE_W-1:0] o_handle,
    input logic [sfl_pkg::CLASS_W-1:0]  o_size_class
);
    import sfl_pkg::*;

    // a command that ends its busy stretch delivers its result at once
    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    a_reject_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_handle == '0 && o_size_class == '0))
        else $error("rejected result carries a handle or class");

    a_zero_size_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_ALLOC && i_size_bytes == '0)
        |=> (o_strobe && o_status == ST_BAD))
        else $error("zero size allocate not rejected");

    a_oversize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_ALLOC && i_size_bytes > SIZE_W'(LARGEST_POOLED))
        |=> (o_strobe && o_status == ST_OVERSIZE))
        else $error("oversize allocate not sent outside");
endmodule

bind size_class_free_list_allocator_core sfl_checker u_sfl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_cmd        (i_cmd),
    .i_size_bytes (i_size_bytes),
    .o_strobe     (o_strobe),
    .o_status     (o_status),
    .o_handle     (o_handle),
    .o_size_class (o_size_class)
);
